>>> rtl/core/phx_pkg.sv
package phx_pkg;

  localparam int WORD_W      = 64;
  localparam int HALF_W      = 32;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 3;
  localparam int CNT_WORDS   = 4;
  localparam int BUF_WORDS   = 4;
  localparam int ROUND_COUNT = 10;
  localparam int RND_W       = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  localparam logic [WORD_W-1:0] MULT_A = 64'hD2E7470EE14C6C93;
  localparam logic [WORD_W-1:0] MULT_B = 64'hCA5A826395121157;
  localparam logic [WORD_W-1:0] BUMP_A = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] BUMP_B = 64'hBB67AE8584CAA73B;

  // buffer position that marks the buffer as empty
  localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(BUF_WORDS);

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_3  = 3'd5;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_WORD    = 2'd0,
    OP_HALF    = 2'd1,
    OP_JUMP    = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic load;
    logic fill_start;
    logic mul;
    logic mix;
    logic last;
    logic emit;
    logic move;
  } phx_cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic buf_empty;
    logic half_pending;
    logic out_free;
  } phx_status_t;

endpackage

>>> rtl/core/phx_if.sv
interface phx_req_if;
  import phx_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  word_t            step;

  modport source (output valid, output opcode, output step, input ready);
  modport sink (input valid, input opcode, input step, output ready);
endinterface

interface phx_rsp_if;
  import phx_pkg::*;

  logic  valid;
  logic  ready;
  word_t random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

>>> rtl/core/philox_4x64_random_generator.sv
// a word request is served from the buffer when it holds one, once the output is free;
// when the buffer is empty, a block of ROUND_COUNT rounds is encrypted first
// requests: one at a time, the next is taken only after the last has been completed
// (one round is a registered 32x32 partial-product step and a recombine/xor step)
// reset: rst is synchronous, clears key and start counter to zero and empties the buffer
module philox_4x64_random_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [phx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  phx_pkg::word_t                cfg_data,
  phx_req_if.sink                       req,
  phx_rsp_if.source                     rsp
);
  import phx_pkg::*;

  phx_cmd_t    cmd;
  phx_status_t status;

  phx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  phx_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_opcode (req.opcode),
    .req_step   (req.step),
    .cmd        (cmd),
    .status     (status),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_value  (rsp.random_value)
  );

endmodule

>>> rtl/core/phx_datapath.sv
module phx_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [phx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  phx_pkg::word_t                cfg_data,
  input  logic [phx_pkg::OP_W-1:0]      req_opcode,
  input  phx_pkg::word_t                req_step,
  input  phx_pkg::phx_cmd_t             cmd,
  output phx_pkg::phx_status_t          status,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output phx_pkg::word_t                rsp_value
);
  import phx_pkg::*;

  word_t key_low, key_high;
  word_t key_low_next, key_high_next;
  word_t start_count [CNT_WORDS];
  word_t start_next [CNT_WORDS];
  word_t counter [CNT_WORDS];
  word_t out_block [BUF_WORDS];
  word_t x [CNT_WORDS];
  word_t k0, k1;
  logic  cfg_hit;

  logic [POS_W-1:0]  pos;
  logic              half_pending;
  logic [HALF_W-1:0] saved_half;
  op_t               opcode;
  word_t             step;
  word_t             rsp_data;

  // partial products: low*low, low*high, high*low, high*high
  logic [2*HALF_W-1:0] p0 [4];
  logic [2*HALF_W-1:0] p1 [4];

  logic [2*WORD_W-1:0]   prod0, prod1;
  word_t                 n0, n1, n2, n3;
  word_t                 sel_word;
  logic [CNT_WORDS*WORD_W-1:0] cnt_flat, cnt_inc, cnt_adv;
  logic [2*WORD_W-1:0]   cnt_jump;

  always_comb begin
    key_low_next  = key_low;
    key_high_next = key_high;
    start_next    = start_count;
    cfg_hit       = 1'b0;
    unique case (cfg_index)
      REG_KEY_LOW: begin
        key_low_next = cfg_data;
        cfg_hit      = 1'b1;
      end
      REG_KEY_HIGH: begin
        key_high_next = cfg_data;
        cfg_hit       = 1'b1;
      end
      REG_START_0: begin
        start_next[0] = cfg_data;
        cfg_hit       = 1'b1;
      end
      REG_START_1: begin
        start_next[1] = cfg_data;
        cfg_hit       = 1'b1;
      end
      REG_START_2: begin
        start_next[2] = cfg_data;
        cfg_hit       = 1'b1;
      end
      REG_START_3: begin
        start_next[3] = cfg_data;
        cfg_hit       = 1'b1;
      end
      default: cfg_hit = 1'b0;
    endcase
  end

  // recombine the registered partial products into 128-bit products
  assign prod0 = {p0[3], p0[0]}
               + {{HALF_W{1'b0}}, p0[1], {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, p0[2], {HALF_W{1'b0}}};
  assign prod1 = {p1[3], p1[0]}
               + {{HALF_W{1'b0}}, p1[1], {HALF_W{1'b0}}}
               + {{HALF_W{1'b0}}, p1[2], {HALF_W{1'b0}}};

  assign n0 = prod1[2*WORD_W-1:WORD_W] ^ x[1] ^ k0;
  assign n1 = prod1[WORD_W-1:0];
  assign n2 = prod0[2*WORD_W-1:WORD_W] ^ x[3] ^ k1;
  assign n3 = prod0[WORD_W-1:0];

  assign sel_word = out_block[pos[1:0]];

  assign cnt_flat = {counter[3], counter[2], counter[1], counter[0]};
  assign cnt_inc  = cnt_flat + (CNT_WORDS*WORD_W)'(1);
  assign cnt_adv  = cnt_flat + {{((CNT_WORDS-1)*WORD_W){1'b0}}, step};
  assign cnt_jump = {counter[3], counter[2]} + (2*WORD_W)'(1);

  // configuration, counter and buffer bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low      <= '0;
      key_high     <= '0;
      for (int i = 0; i < CNT_WORDS; i++) begin
        start_count[i] <= '0;
        counter[i]     <= '0;
      end
      pos          <= POS_EMPTY;
      half_pending <= 1'b0;
    end else if (cfg_write && cfg_hit) begin
      key_low      <= key_low_next;
      key_high     <= key_high_next;
      start_count  <= start_next;
      counter      <= start_next;
      pos          <= POS_EMPTY;
      half_pending <= 1'b0;
    end else begin
      if (cmd.mix && cmd.last) begin
        for (int i = 0; i < CNT_WORDS; i++) begin
          counter[i] <= cnt_inc[i*WORD_W +: WORD_W];
        end
        pos <= '0;
      end
      if (cmd.emit) begin
        if (opcode == OP_HALF && half_pending) begin
          half_pending <= 1'b0;
        end else begin
          pos <= pos + POS_W'(1);
          if (opcode == OP_HALF) begin
            half_pending <= 1'b1;
          end
        end
      end
      if (cmd.move) begin
        if (opcode == OP_JUMP) begin
          counter[2] <= cnt_jump[WORD_W-1:0];
          counter[3] <= cnt_jump[2*WORD_W-1:WORD_W];
        end else begin
          for (int i = 0; i < CNT_WORDS; i++) begin
            counter[i] <= cnt_adv[i*WORD_W +: WORD_W];
          end
        end
        pos          <= POS_EMPTY;
        half_pending <= 1'b0;
      end
    end
  end

  // round datapath and output data
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode <= op_t'(req_opcode);
      step   <= req_step;
    end
    if (cmd.fill_start) begin
      x  <= counter;
      k0 <= key_low;
      k1 <= key_high;
    end
    if (cmd.mul) begin
      p0[0] <= x[0][HALF_W-1:0]      * MULT_A[HALF_W-1:0];
      p0[1] <= x[0][HALF_W-1:0]      * MULT_A[WORD_W-1:HALF_W];
      p0[2] <= x[0][WORD_W-1:HALF_W] * MULT_A[HALF_W-1:0];
      p0[3] <= x[0][WORD_W-1:HALF_W] * MULT_A[WORD_W-1:HALF_W];
      p1[0] <= x[2][HALF_W-1:0]      * MULT_B[HALF_W-1:0];
      p1[1] <= x[2][HALF_W-1:0]      * MULT_B[WORD_W-1:HALF_W];
      p1[2] <= x[2][WORD_W-1:HALF_W] * MULT_B[HALF_W-1:0];
      p1[3] <= x[2][WORD_W-1:HALF_W] * MULT_B[WORD_W-1:HALF_W];
    end
    if (cmd.mix) begin
      x[0] <= n0;
      x[1] <= n1;
      x[2] <= n2;
      x[3] <= n3;
      // key bump for the following round
      k0   <= k0 + BUMP_A;
      k1   <= k1 + BUMP_B;
      if (cmd.last) begin
        out_block[0] <= n0;
        out_block[1] <= n1;
        out_block[2] <= n2;
        out_block[3] <= n3;
      end
    end
    if (cmd.emit) begin
      if (opcode == OP_HALF) begin
        if (half_pending) begin
          rsp_data <= {{HALF_W{1'b0}}, saved_half};
        end else begin
          rsp_data   <= {{HALF_W{1'b0}}, sel_word[HALF_W-1:0]};
          saved_half <= sel_word[WORD_W-1:HALF_W];
        end
      end else begin
        rsp_data <= sel_word;
      end
    end
  end

  // output register, parts the request side from the response side
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp_value           = rsp_data;
  assign status.opcode       = opcode;
  assign status.buf_empty    = pos[POS_W-1];
  assign status.half_pending = half_pending;
  assign status.out_free     = !rsp_valid || rsp_ready;

endmodule

>>> rtl/core/phx_ctrl.sv
module phx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  phx_pkg::phx_status_t status,
  output phx_pkg::phx_cmd_t    cmd
);
  import phx_pkg::*;

  state_t           state, state_next;
  logic [RND_W-1:0] rnd, rnd_next;
  logic             need_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  // a pending high half is served without touching the buffer
  assign need_fill = status.buf_empty &&
                     !(status.opcode == OP_HALF && status.half_pending);

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.opcode) inside
          OP_WORD, OP_HALF: begin
            if (need_fill) begin
              cmd.fill_start = 1'b1;
              rnd_next       = '0;
              state_next     = ST_MUL;
            end else if (status.out_free) begin
              cmd.emit   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_JUMP, OP_ADVANCE: begin
            cmd.move   = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        if (rnd == RND_W'(ROUND_COUNT - 1)) begin
          cmd.last   = 1'b1;
          state_next = ST_EXEC;
        end else begin
          rnd_next   = rnd + RND_W'(1);
          state_next = ST_MUL;
        end
      end
    endcase
  end

endmodule

>>> rtl/core/phx_checker.sv
module phx_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input phx_pkg::word_t rsp_value
);
  import phx_pkg::*;

  // a stalled word stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
    else $error("response word changed or dropped while stalled");

  // one request at a time: an accept closes the request side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request side still open after an accept");

  // a new word is only produced while the request side is closed
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("word produced while idle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind philox_4x64_random_generator phx_checker u_phx_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.random_value)
);
